>>> rtl/bounded_deque_with_remove_unit_defines.svh
// ----------------------------------------------------------------------------
// bounded deque unit: assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_REMOVE_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_REMOVE_UNIT_DEFINES_SVH

// condition holds in the same cycle as its trigger
`define BDWR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after its trigger
`define BDWR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bdwr_pkg.sv
// ----------------------------------------------------------------------------
// bdwr_pkg
// request codes, operation classes, status codes and the queued command type
// ----------------------------------------------------------------------------
package bdwr_pkg;

  localparam int TYPE_W  = 3;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 16;

  // request type codes as they arrive on the port
  localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_REMOVE     = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_CLEAR      = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_SIZE       = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_GET        = 3'd7;

  // decoded operation, one-hot
  typedef enum logic [7:0] {
    OP_PUSH_BACK  = 8'b0000_0001,
    OP_PUSH_FRONT = 8'b0000_0010,
    OP_POP_BACK   = 8'b0000_0100,
    OP_POP_FRONT  = 8'b0000_1000,
    OP_REMOVE     = 8'b0001_0000,
    OP_CLEAR      = 8'b0010_0000,
    OP_SIZE       = 8'b0100_0000,
    OP_GET        = 8'b1000_0000
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  // classified request held in the command queue
  typedef struct packed {
    op_t                op;
    logic [DATA_W-1:0]  value;
    logic [INDEX_W-1:0] index;
  } cmd_t;

endpackage

>>> rtl/bdwr_ram.sv
// ----------------------------------------------------------------------------
// bdwr_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module bdwr_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bdwr_front.sv
// ----------------------------------------------------------------------------
// bdwr_front
// takes requests, decodes the request type and holds them in a two-entry
// command queue for the back end
// ----------------------------------------------------------------------------
module bdwr_front import bdwr_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [TYPE_W-1:0]         req_type,
  input  logic signed [DATA_W-1:0]  value,
  input  logic [INDEX_W-1:0]        index,
  output logic                      cmd_valid,
  output cmd_t                      cmd,
  input  logic                      take
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic [1:0] fill_next;
  logic       push;
  op_t        op_dec;

  // request type decode
  always_comb begin
    unique case (req_type)
      REQ_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      REQ_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      REQ_POP_BACK:   op_dec = OP_POP_BACK;
      REQ_POP_FRONT:  op_dec = OP_POP_FRONT;
      REQ_REMOVE:     op_dec = OP_REMOVE;
      REQ_CLEAR:      op_dec = OP_CLEAR;
      REQ_SIZE:       op_dec = OP_SIZE;
      REQ_GET:        op_dec = OP_GET;
      default:        op_dec = OP_SIZE;
    endcase
  end

  // queue handshake
  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !take) begin
      fill_next = fill + 2'd1;
    end else if (take && !push) begin
      fill_next = fill - 2'd1;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op_dec, value: value, index: index};
    end
  end

endmodule

>>> rtl/bdwr_back.sv
// ----------------------------------------------------------------------------
// bdwr_back
// carries out queued commands on the ring store: pushes, pops, clear and
// size in one pass, get as a store read then a result load, remove as a
// read-compare scan followed by a read-write shift that closes the gap;
// drives the result register
module bdwr_back import bdwr_pkg::*; #(
  parameter int  DEPTH = 16,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  cmd_t                      cmd,
  output logic                      take,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic signed [DATA_W-1:0]  data,
  output logic [2:0]                status,
  output logic [CW-1:0]             level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW = CW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [RW-1:0] DEPTH_R  = RW'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_GET   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_t;

  // ring position of an offset from the front
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [RW-1:0] sum;
    sum = RW'(base) + RW'(off);
    if (sum >= DEPTH_R) begin
      sum = sum - DEPTH_R;
    end
    return sum[AW-1:0];
  endfunction

  state_t            state, state_next;
  logic [AW-1:0]     front, front_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     off, off_next;
  logic [DATA_W-1:0] match_val, match_val_next;

  logic              res_valid;
  logic [DATA_W-1:0] res_data;
  status_t           res_status;
  logic              res_load;
  logic [DATA_W-1:0] res_data_new;
  status_t           res_status_new;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [CW-1:0]     rd_off;
  logic [DATA_W-1:0] rd_data;

  logic              out_free;
  logic              is_full;
  logic              is_empty;
  logic [AW-1:0]     front_dec;
  logic [AW-1:0]     front_inc;
  logic [CW-1:0]     off_inc;
  logic [CW-1:0]     off_inc2;

  assign out_free  = !res_valid || !rsp_stall;
  assign is_full   = (count == FULL_CNT);
  assign is_empty  = (count == '0);
  assign front_dec = (front == '0) ? LAST_POS : front - 1'b1;
  assign front_inc = (front == LAST_POS) ? '0 : front + 1'b1;
  assign off_inc   = off + 1'b1;
  assign off_inc2  = off + CW'(2);

  // command sequencer
  always_comb begin
    state_next     = state;
    front_next     = front;
    count_next     = count;
    off_next       = off;
    match_val_next = match_val;
    take           = 1'b0;
    res_load       = 1'b0;
    res_data_new   = '0;
    res_status_new = ST_OK;
    wr_en          = 1'b0;
    wr_addr        = ring_pos(front, count);
    wr_data        = cmd.value;
    rd_en          = 1'b0;
    rd_off         = '0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          take     = 1'b1;
          res_load = 1'b1;
          unique case (cmd.op)
            OP_PUSH_BACK: begin
              if (is_full) begin
                res_status_new = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (is_full) begin
                res_status_new = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = front_dec;
                front_next = front_dec;
                count_next = count + 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                res_status_new = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                res_status_new = ST_EMPTY;
              end else begin
                front_next = front_inc;
                count_next = count - 1'b1;
              end
            end
            OP_REMOVE: begin
              if (is_empty) begin
                res_status_new = ST_NOT_FOUND;
              end else begin
                res_load       = 1'b0;
                rd_en          = 1'b1;
                rd_off         = '0;
                off_next       = '0;
                match_val_next = cmd.value;
                state_next     = S_SCAN;
              end
            end
            OP_CLEAR: begin
              count_next = '0;
              front_next = '0;
            end
            OP_SIZE: begin
              res_data_new = DATA_W'(count);
            end
            OP_GET: begin
              if (cmd.index >= INDEX_W'(count)) begin
                res_status_new = ST_RANGE;
              end else begin
                res_load   = 1'b0;
                rd_en      = 1'b1;
                rd_off     = CW'(cmd.index);
                state_next = S_GET;
              end
            end
            default: begin
              res_status_new = ST_OK;
            end
          endcase
        end
      end
      S_GET: begin
        res_load     = 1'b1;
        res_data_new = rd_data;
        state_next   = S_IDLE;
      end
      // read data belongs to offset off
      S_SCAN: begin
        if (rd_data == match_val) begin
          if (off_inc == count) begin
            count_next = count - 1'b1;
            res_load   = 1'b1;
            state_next = S_IDLE;
          end else begin
            rd_en      = 1'b1;
            rd_off     = off_inc;
            state_next = S_SHIFT;
          end
        end else if (off_inc == count) begin
          res_load       = 1'b1;
          res_status_new = ST_NOT_FOUND;
          state_next     = S_IDLE;
        end else begin
          rd_en    = 1'b1;
          rd_off   = off_inc;
          off_next = off_inc;
        end
      end
      // read data belongs to offset off+1 and moves down to off
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ring_pos(front, off);
        wr_data = rd_data;
        if (off_inc2 < count) begin
          rd_en    = 1'b1;
          rd_off   = off_inc2;
          off_next = off_inc;
        end else begin
          count_next = count - 1'b1;
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      front <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
    end
  end

  // scan offset and match value
  always_ff @(posedge clk) begin
    off       <= off_next;
    match_val <= match_val_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!rsp_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data   <= res_data_new;
      res_status <= res_status_new;
    end
  end

  assign rsp_valid = res_valid;
  assign data      = res_data;
  assign status    = res_status;
  assign level     = count;

  // entry store
  bdwr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ring_pos(front, rd_off)),
    .rd_data (rd_data)
  );

endmodule

>>> rtl/bounded_deque_with_remove_unit.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_remove_unit
// bounded double-ended queue of signed 32-bit values with remove by value
// ----------------------------------------------------------------------------
// requests enter on req_valid/req_stall with req_type, value and index; each
// request gives exactly one result on rsp_valid/rsp_stall with data, status.
// a two-entry command queue sits between the request port and the executor,
// so requests keep arriving while a result waits in the output register.
// a request is first written into the command queue; the executor then takes
// it and loads the output register. get reads the store first and loads the
// result from S_GET. push, pop, clear and size run at one request per cycle
// while the output register is not held by rsp_stall; get keeps the executor
// in S_GET before it takes the next request. remove scans the ring one entry
// per cycle through the store's read port, then shifts the later entries down
// one per cycle (read and write port in parallel); on an empty deque remove
// answers straight away with a not-found status.
// reset empties the deque and the queue at once; the store needs no clearing.
// while rsp_stall is high the result holds, the executor waits for the
// output register and the queue fills, after which req_stall rises.
// ----------------------------------------------------------------------------
`include "bounded_deque_with_remove_unit_defines.svh"

module bounded_deque_with_remove_unit import bdwr_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  logic [TYPE_W-1:0]         req_type,
  input  logic signed [DATA_W-1:0]  value,
  input  logic [INDEX_W-1:0]        index,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output logic signed [DATA_W-1:0]  data,
  output logic [2:0]                status
);

  localparam int CW = $clog2(DEPTH + 1);

  logic          cmd_valid;
  cmd_t          cmd;
  logic          take;
  logic [CW-1:0] level;

  // request decode and command queue
  bdwr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .value     (value),
    .index     (index),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take)
  );

  // executor and result register
  bdwr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .take      (take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .data      (data),
    .status    (status),
    .level     (level)
  );

  // checks
  `BDWR_ASSERT_IMP(a_take_has_cmd, clk, rst, take, cmd_valid, "command taken from empty queue")
  `BDWR_ASSERT_IMP(a_take_slot_free, clk, rst, take, (!rsp_valid || !rsp_stall), "command taken while result blocked")
  `BDWR_ASSERT_NXT(a_clear_empties, clk, rst, (take && cmd.op == OP_CLEAR), (level == '0), "clear left entries behind")

endmodule
